// ===== src/itoa_pkg.sv =====
// shared types, constants and power-of-ten table for the decimal text converter
`timescale 1ns / 1ps

package itoa_pkg;

    localparam logic [3:0] LastPos = 4'd9;
    localparam logic [5:0] ChZero  = 6'd48;
    localparam logic [5:0] ChMinus = 6'd45;

    typedef logic [31:0] t_word;
    typedef logic [3:0]  t_pos;
    typedef logic [5:0]  t_char;

    typedef struct packed {
        logic load;
        logic sign;
        logic digit;
    } t_cmd;

    typedef struct packed {
        logic in_neg;
        logic pos_zero;
    } t_sts;

    function automatic t_word pow10(input t_pos pos);
        t_word p;
        case (pos)
            4'd0:    p = 32'd1;
            4'd1:    p = 32'd10;
            4'd2:    p = 32'd100;
            4'd3:    p = 32'd1000;
            4'd4:    p = 32'd10000;
            4'd5:    p = 32'd100000;
            4'd6:    p = 32'd1000000;
            4'd7:    p = 32'd10000000;
            4'd8:    p = 32'd100000000;
            4'd9:    p = 32'd1000000000;
            default: p = 32'd1;
        endcase
        return p;
    endfunction

endpackage

// ===== src/itoa_ctrl.sv =====
// controller state machine: sign beat for a negative value, then one decimal position per cycle
`timescale 1ns / 1ps

module itoa_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           start,
    output logic           busy,
    input  itoa_pkg::t_sts i_sts,
    output itoa_pkg::t_cmd o_cmd
);
    import itoa_pkg::*;

    localparam logic [1:0] StIdle  = 2'd0;
    localparam logic [1:0] StSign  = 2'd1;
    localparam logic [1:0] StDigit = 2'd2;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            StIdle: begin
                if (start) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_sts.in_neg ? StSign : StDigit;
                end
            end
            StSign: begin
                o_cmd.sign = 1'b1;
                n_state    = StDigit;
            end
            StDigit: begin
                o_cmd.digit = 1'b1;
                if (i_sts.pos_zero) begin
                    n_state = StIdle;
                end
            end
            default: begin
                n_state = StIdle;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= StIdle;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy = (r_state != StIdle);

endmodule

// ===== src/itoa_dp.sv =====
// datapath: magnitude register, digit select against power-of-ten multiples, output beat
`timescale 1ns / 1ps

module itoa_dp (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic signed [31:0]     i_value,
    input  itoa_pkg::t_cmd         i_cmd,
    output itoa_pkg::t_sts         o_sts,
    output logic [5:0]             o_char_code,
    output logic                   o_last,
    output logic                   o_valid
);
    import itoa_pkg::*;

    t_word       r_rem;
    t_pos        r_pos;
    logic        r_started;
    logic        r_valid;
    t_char       r_char;
    logic        r_last;

    t_word       raw;
    t_word       mag;
    t_word       p;
    logic [33:0] cand;
    logic [33:0] sub;
    logic [33:0] diff;
    logic [3:0]  digit;
    t_word       n_rem;
    logic        emit_digit;

    always_comb begin
        raw = t_word'(i_value);
        mag = raw[31] ? (~raw + 32'd1) : raw;
    end

    // largest multiple of the position weight that fits
    always_comb begin
        p     = pow10(r_pos);
        digit = '0;
        sub   = '0;
        cand  = '0;
        for (int d = 1; d < 10; d++) begin
            cand = 34'(d) * {2'b00, p};
            if ({2'b00, r_rem} >= cand) begin
                digit = 4'(d);
                sub   = cand;
            end
        end
        diff  = {2'b00, r_rem} - sub;
        n_rem = diff[31:0];
    end

    assign emit_digit = i_cmd.digit &&
                        ((digit != 4'd0) || r_started || (r_pos == 4'd0));

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_rem <= mag;
        end else if (i_cmd.digit) begin
            r_rem <= n_rem;
        end
        r_char <= i_cmd.sign ? ChMinus : (ChZero + {2'b00, digit});
        r_last <= i_cmd.digit && (r_pos == 4'd0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos     <= '0;
            r_started <= 1'b0;
            r_valid   <= 1'b0;
        end else begin
            r_valid <= i_cmd.sign || emit_digit;
            if (i_cmd.load) begin
                r_pos     <= LastPos;
                r_started <= 1'b0;
            end else if (i_cmd.digit) begin
                r_pos <= r_pos - 4'd1;
                if (digit != 4'd0) begin
                    r_started <= 1'b1;
                end
            end
        end
    end

    assign o_sts.in_neg   = i_value[31];
    assign o_sts.pos_zero = (r_pos == 4'd0);
    assign o_char_code    = r_char;
    assign o_last         = r_last;
    assign o_valid        = r_valid;

endmodule

// ===== src/integer_to_decimal_ascii_top.sv =====
// top level of the signed 32-bit integer to decimal ascii converter
//
// usage:
//   drive i_value and raise start; the value is taken at a rising edge where
//   start is high and busy is low. busy stays high while the text is produced.
//   each output beat is one character on o_char_code, marked by o_valid for
//   exactly one cycle; o_last is high on the final character of the number.
//   a negative value gives '-' first; leading zeros are dropped, zero gives '0'.
//   the first character is the '-' registered from the sign beat for a negative
//   value, otherwise the digit of the first nonzero decimal position (or of the
//   last position for zero); the controller walks all ten decimal positions one
//   per cycle after any sign beat, and takes no new value until it is idle.
//   the final beat appears in the cycle busy falls, so a new value can be
//   accepted while it is on the outputs.
//   reset (synchronous, active low) drops busy and o_valid and abandons any
//   text in progress. the receiver takes every beat; there is no back-pressure.
`timescale 1ns / 1ps

module integer_to_decimal_ascii_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] i_value,
    output logic [5:0]         o_char_code,
    output logic               o_last,
    output logic               o_valid
);
    import itoa_pkg::*;

    t_cmd cmd;
    t_sts sts;

    itoa_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    itoa_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_value     (i_value),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .o_char_code (o_char_code),
        .o_last      (o_last),
        .o_valid     (o_valid)
    );

endmodule

// ===== src/itoa_chk.sv =====
// port-level checker for the decimal text converter, bound to the top level
`timescale 1ns / 1ps

module itoa_chk (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               start,
    input logic               busy,
    input logic signed [31:0] i_value,
    input logic [5:0]         o_char_code,
    input logic               o_last,
    input logic               o_valid
);

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accept");

    a_gap_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last) |=> !o_valid)
        else $error("beat directly after final character");

    a_sign_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_char_code == 6'd45)) |-> !o_last)
        else $error("minus sign marked final");

    a_char_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> ((o_char_code == 6'd45) ||
                     ((o_char_code >= 6'd48) && (o_char_code <= 6'd57))))
        else $error("character code out of range");

    a_done_with_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($fell(busy) && $past(i_rst_n)) |-> (o_valid && o_last))
        else $error("busy fell without final character");

endmodule

bind integer_to_decimal_ascii_top itoa_chk u_itoa_chk (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .i_value     (i_value),
    .o_char_code (o_char_code),
    .o_last      (o_last),
    .o_valid     (o_valid)
);
